[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the slot pool checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define FSP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("slot pool assertion failed");

// condition must never be true outside reset
`define FSP_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("slot pool forbidden condition");

`endif

[rtl/fsp_pkg.sv]
// ----------------------------------------------------------------------------
// fsp_pkg
// Types and constants of the frame slot pool manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsp_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int CNT_W   = 7;
  localparam int SEQ_W   = 64;
  localparam int TS_W    = 63;
  localparam int FR_W    = 48;
  localparam int SF_W    = 49;
  localparam int EV_W    = 48;
  localparam int NOM_W   = 32;
  localparam int SIU_W   = 6;
  localparam int LIM_MAX = 32;
  localparam int IN_W    = 128;
  localparam int OUT_W   = 200;
  localparam int ADDR_W  = 3;
  localparam int NUM_EV  = 6;

  localparam int EV_PUSHED   = 0;
  localparam int EV_NOSLOT   = 1;
  localparam int EV_RECYCLED = 2;
  localparam int EV_GAPS     = 3;
  localparam int EV_COUNT    = 4;
  localparam int EV_LDROPS   = 5;

  localparam logic [3:0] STAT_PUSHED   = 4'd0;
  localparam logic [3:0] STAT_NOSLOT   = 4'd1;
  localparam logic [3:0] STAT_RECYCLED = 4'd2;
  localparam logic [3:0] STAT_GAPS     = 4'd3;
  localparam logic [3:0] STAT_MAX      = 4'd4;
  localparam logic [3:0] STAT_LAST     = 4'd5;
  localparam logic [3:0] STAT_SUM      = 4'd6;
  localparam logic [3:0] STAT_CNT      = 4'd7;
  localparam logic [3:0] STAT_LDROPS   = 4'd8;

  localparam logic REG_SLOTS   = 1'b0;
  localparam logic REG_NOMINAL = 1'b1;

  typedef enum logic [2:0] {
    OP_BEGIN  = 3'd0,
    OP_COMMIT = 3'd1,
    OP_ABORT  = 3'd2,
    OP_LOCK   = 3'd3,
    OP_UNLOCK = 3'd4,
    OP_RSTAT  = 3'd5,
    OP_RDSTAT = 3'd6,
    OP_NOP    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_WRITING = 2'd1,
    ST_READY   = 2'd2,
    ST_LOCKED  = 2'd3
  } slot_st_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_CMT_A = 9'b000000100,
    S_CMT_B = 9'b000001000,
    S_APPLY = 9'b000010000,
    S_LSET  = 9'b000100000,
    S_LOCK  = 9'b001000000,
    S_LRD   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } fsp_state_e;

  typedef struct packed {
    logic clear;
    logic en;
    logic max_mode;
  } cmp_ctrl_t;

endpackage

[rtl/fsp_mem.sv]
// ----------------------------------------------------------------------------
// fsp_mem
// Per-slot sequence, timestamp and frame number storage, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsp_mem #(
  parameter int SLOT_COUNT = fsp_pkg::SLOT_COUNT_DEF,
  parameter int IDX_W      = 5
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [IDX_W-1:0]          waddr_i,
  input  logic [fsp_pkg::SEQ_W-1:0] wseq_i,
  input  logic [fsp_pkg::TS_W-1:0]  wts_i,
  input  logic [fsp_pkg::FR_W-1:0]  wfr_i,
  input  logic [IDX_W-1:0]          raddr_i,
  output logic [fsp_pkg::SEQ_W-1:0] rseq_o,
  output logic [fsp_pkg::TS_W-1:0]  rts_o,
  output logic [fsp_pkg::FR_W-1:0]  rfr_o
);
  import fsp_pkg::*;

  logic [SEQ_W-1:0] seq_mem [SLOT_COUNT];
  logic [TS_W-1:0]  ts_mem  [SLOT_COUNT];
  logic [FR_W-1:0]  fr_mem  [SLOT_COUNT];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      seq_mem[waddr_i] <= wseq_i;
      ts_mem[waddr_i]  <= wts_i;
      fr_mem[waddr_i]  <= wfr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rseq_o <= seq_mem[raddr_i];
    rts_o  <= ts_mem[raddr_i];
    rfr_o  <= fr_mem[raddr_i];
  end

endmodule

[rtl/fsp_cmp.sv]
// ----------------------------------------------------------------------------
// fsp_cmp
// Shared signed sequence comparator tracking the best slot of a scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsp_cmp #(
  parameter int IDX_W = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fsp_pkg::cmp_ctrl_t        ctrl_i,
  input  logic                      elig_i,
  input  logic [fsp_pkg::SEQ_W-1:0] key_i,
  input  logic [IDX_W-1:0]          idx_i,
  output logic                      best_vld_o,
  output logic [IDX_W-1:0]          best_idx_o
);
  import fsp_pkg::*;

  logic [SEQ_W-1:0] best_key_q;
  logic [SEQ_W-1:0] a_key;
  logic [SEQ_W-1:0] b_key;
  logic             take;

  assign a_key = key_i ^ {1'b1, {(SEQ_W-1){1'b0}}};
  assign b_key = best_key_q ^ {1'b1, {(SEQ_W-1){1'b0}}};
  assign take  = !best_vld_o || (ctrl_i.max_mode ? (a_key > b_key) : (a_key < b_key));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_o <= 1'b0;
    end else if (ctrl_i.clear) begin
      best_vld_o <= 1'b0;
    end else if (ctrl_i.en && elig_i && take) begin
      best_vld_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ctrl_i.clear && ctrl_i.en && elig_i && take) begin
      best_key_q <= key_i;
      best_idx_o <= idx_i;
    end
  end

endmodule

[rtl/frame_slot_pool_manager.sv]
// ----------------------------------------------------------------------------
// frame_slot_pool_manager
// Frame buffer slot pool: grant, commit, abort, lock newest, unlock, stats.
// ----------------------------------------------------------------------------
// One command is taken at a time; s_tready is high only while idle. Every
// command but lock_newest walks the active slots once through a single
// compare unit, one slot per cycle behind a registered table read, then waits
// for the output to be taken; begin_write adds one more walk, and commit adds
// the S_CMT_A and S_CMT_B steps. read_stats gives nine items after one walk.
// lock_newest takes one counting walk and then one walk per locked slot. No
// clearing pass is needed after reset.
`timescale 1ns / 1ps

module frame_slot_pool_manager #(
  parameter int SLOT_COUNT = fsp_pkg::SLOT_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // opcode, slot_number, timestamp_ns, frame_number, lock_count
  input  logic [fsp_pkg::IN_W-1:0]   s_tdata,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // ok, granted_slot, slot_timestamp, slot_frame, stat_index, stat_value,
  // ready_slots, locked_slots
  output logic [fsp_pkg::OUT_W-1:0]  m_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic                       m_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fsp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import fsp_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [SIU_W-1:0] siu_q;
  logic [NOM_W-1:0] nom_q;
  logic [CNT_W-1:0] act;

  fsp_state_e state_q, state_d;
  logic       go_scan;
  logic       done;

  op_e              op_q;
  logic [4:0]       slot_q;
  logic [TS_W-1:0]  ts_q;
  logic [FR_W-1:0]  fr_q;
  logic [5:0]       want_q;
  op_e              in_op;

  slot_st_e           status_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] seqv_q;
  logic [SLOT_COUNT-1:0] seqneg_q;

  logic [SEQ_W-1:0] next_seq_q;
  logic [5:0]       locked_q;
  logic [TS_W-1:0]  prev_q;
  logic [EV_W-1:0]  ev_q [NUM_EV];
  logic [TS_W-1:0]  max_q, last_q, sum_q, sum_nx_q, dt_q;
  logic             gt_q, gap_q;

  logic [CNT_W-1:0] scan_q, cnt_q;
  logic             pv_q, pseqv_q;
  logic [IDX_W-1:0] pidx_q;
  slot_st_e         pst_q;
  logic             final_q, lscan_q, max_mode_q;
  logic [5:0]       lk_q, n_q;

  logic             mv_q, o_ok_q, o_last_q;
  logic [4:0]       o_slot_q;
  logic [TS_W-1:0]  o_ts_q;
  logic [SF_W-1:0]  o_fr_q;
  logic [3:0]       o_idx_q;
  logic [5:0]       o_ready_q, o_locked_q;
  logic [TS_W-1:0]  stat_val;

  logic [CNT_W-1:0] slot_ext;
  logic [IDX_W-1:0] sidx;
  logic             s_in;
  logic [63:0]      diff;
  logic [33:0]      nom3;
  logic [63:0]      sum_add;
  logic [5:0]       lim, n_sel;
  logic [6:0]       lsum;

  logic             mem_we;
  logic [IDX_W-1:0] mem_raddr;
  logic [SEQ_W-1:0] rseq;
  logic [TS_W-1:0]  rts;
  logic [FR_W-1:0]  rfr;

  cmp_ctrl_t        cmp_ctrl;
  logic             cmp_elig;
  logic [SEQ_W-1:0] cmp_key;
  logic             best_vld;
  logic [IDX_W-1:0] best_idx;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NOMINAL) ? nom_q : 32'(siu_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      siu_q <= SIU_W'(32);
      nom_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_SLOTS:   siu_q <= pwdata[SIU_W-1:0];
        REG_NOMINAL: nom_q <= pwdata;
        default: ;
      endcase
    end
  end

  assign act = (CNT_W'(siu_q) > CNT_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT) : CNT_W'(siu_q);

  assign in_op    = op_e'(s_tdata[2:0]);
  assign slot_ext = CNT_W'(slot_q);
  assign sidx     = slot_ext[IDX_W-1:0];
  assign s_in     = slot_ext < act;
  assign diff     = {1'b0, ts_q} - {1'b0, prev_q};
  assign nom3     = {2'b0, nom_q} + {1'b0, nom_q, 1'b0};
  assign sum_add  = {1'b0, sum_q} + {1'b0, dt_q};
  assign lim      = (want_q > 6'(LIM_MAX)) ? 6'(LIM_MAX) : want_q;
  assign n_sel    = (CNT_W'(lim) < cnt_q) ? lim : cnt_q[5:0];
  assign lsum     = {1'b0, locked_q} + {1'b0, n_sel};
  assign done     = (scan_q >= act) && !pv_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid) begin
          case (in_op)
            OP_BEGIN, OP_LOCK, OP_RDSTAT: state_d = S_SCAN;
            OP_COMMIT:                    state_d = S_CMT_A;
            default:                      state_d = S_APPLY;
          endcase
        end
      end
      S_SCAN: begin
        if (done) begin
          if (final_q)              state_d = S_EMIT;
          else if (op_q == OP_LOCK) state_d = lscan_q ? S_LOCK : S_LSET;
          else                      state_d = S_APPLY;
        end
      end
      S_CMT_A: state_d = S_CMT_B;
      S_CMT_B: state_d = S_APPLY;
      S_APPLY: state_d = S_SCAN;
      S_LSET:  state_d = (n_sel == '0) ? S_EMIT : S_SCAN;
      S_LOCK:  state_d = S_LRD;
      S_LRD:   state_d = S_EMIT;
      S_EMIT: begin
        if (m_tready) begin
          if (o_last_q)             state_d = S_IDLE;
          else if (op_q == OP_LOCK) state_d = S_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign go_scan  = (state_d == S_SCAN) && (state_q != S_SCAN);
  assign s_tready = (state_q == S_IDLE);

  assign cmp_ctrl.clear    = go_scan;
  assign cmp_ctrl.en       = (state_q == S_SCAN) && pv_q;
  assign cmp_ctrl.max_mode = max_mode_q;
  assign cmp_elig = max_mode_q ? (pst_q == ST_READY) :
                    ((pst_q == ST_FREE) || (pst_q == ST_READY));
  assign cmp_key  = pseqv_q ? rseq : '1;

  assign mem_we    = (state_q == S_CMT_A) && s_in;
  assign mem_raddr = (state_q == S_LOCK) ? best_idx : scan_q[IDX_W-1:0];

  fsp_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (sidx),
    .wseq_i  (next_seq_q),
    .wts_i   (ts_q),
    .wfr_i   (fr_q),
    .raddr_i (mem_raddr),
    .rseq_o  (rseq),
    .rts_o   (rts),
    .rfr_o   (rfr)
  );

  fsp_cmp #(
    .IDX_W (IDX_W)
  ) u_cmp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (cmp_ctrl),
    .elig_i     (cmp_elig),
    .key_i      (cmp_key),
    .idx_i      (pidx_q),
    .best_vld_o (best_vld),
    .best_idx_o (best_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      for (int i = 0; i < SLOT_COUNT; i++) status_q[i] <= ST_FREE;
      seqv_q     <= '0;
      seqneg_q   <= '1;
      next_seq_q <= '0;
      locked_q   <= '0;
      prev_q     <= '0;
      for (int i = 0; i < NUM_EV; i++) ev_q[i] <= '0;
      max_q      <= '0;
      last_q     <= '0;
      sum_q      <= '0;
      scan_q     <= '0;
      cnt_q      <= '0;
      pv_q       <= 1'b0;
      final_q    <= 1'b0;
      lscan_q    <= 1'b0;
      max_mode_q <= 1'b0;
      lk_q       <= '0;
      n_q        <= '0;
      mv_q       <= 1'b0;
    end else begin
      state_q <= state_d;

      if (go_scan) begin
        scan_q <= '0;
        cnt_q  <= '0;
        pv_q   <= 1'b0;
      end else if (state_q == S_SCAN) begin
        if (scan_q < act) begin
          pidx_q  <= scan_q[IDX_W-1:0];
          pst_q   <= status_q[scan_q[IDX_W-1:0]];
          pseqv_q <= seqv_q[scan_q[IDX_W-1:0]];
          pv_q    <= 1'b1;
          scan_q  <= scan_q + CNT_W'(1);
        end else begin
          pv_q <= 1'b0;
        end
        if (pv_q && (pst_q == ST_READY)) cnt_q <= cnt_q + CNT_W'(1);
      end

      case (state_q)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q       <= in_op;
            slot_q     <= s_tdata[7:3];
            ts_q       <= s_tdata[70:8];
            fr_q       <= s_tdata[118:71];
            want_q     <= s_tdata[124:119];
            final_q    <= (in_op == OP_RDSTAT);
            lscan_q    <= 1'b0;
            max_mode_q <= 1'b0;
            lk_q       <= '0;
            o_ok_q     <= 1'b0;
            o_slot_q   <= '0;
            o_ts_q     <= '0;
            o_fr_q     <= '0;
            o_idx_q    <= '0;
            o_last_q   <= (in_op != OP_RDSTAT);
          end
        end
        S_SCAN: begin
          if (done && final_q) begin
            o_ready_q  <= cnt_q[5:0];
            o_locked_q <= locked_q;
            mv_q       <= 1'b1;
          end
        end
        S_CMT_A: begin
          dt_q <= diff[TS_W-1:0];
          gt_q <= !diff[63] && (diff != '0);
        end
        S_CMT_B: begin
          sum_nx_q <= sum_add[63] ? '1 : sum_add[TS_W-1:0];
          gap_q    <= (nom_q != '0) && ({1'b0, dt_q, 1'b0} > {31'b0, nom3});
        end
        S_APPLY: begin
          final_q <= 1'b1;
          case (op_q)
            OP_BEGIN: begin
              if (!best_vld) begin
                if (locked_q != '0) ev_q[EV_LDROPS] <= ev_q[EV_LDROPS] + EV_W'(1);
                else                ev_q[EV_NOSLOT] <= ev_q[EV_NOSLOT] + EV_W'(1);
              end else begin
                if (status_q[best_idx] == ST_READY)
                  ev_q[EV_RECYCLED] <= ev_q[EV_RECYCLED] + EV_W'(1);
                status_q[best_idx] <= ST_WRITING;
                o_ok_q   <= 1'b1;
                o_slot_q <= 5'(best_idx);
              end
            end
            OP_COMMIT: begin
              if (s_in) begin
                status_q[sidx] <= ST_READY;
                seqv_q[sidx]   <= 1'b1;
                seqneg_q[sidx] <= next_seq_q[SEQ_W-1];
                next_seq_q     <= next_seq_q + SEQ_W'(1);
                ev_q[EV_PUSHED] <= ev_q[EV_PUSHED] + EV_W'(1);
                if ((prev_q != '0) && gt_q) begin
                  last_q <= dt_q;
                  sum_q  <= sum_nx_q;
                  ev_q[EV_COUNT] <= ev_q[EV_COUNT] + EV_W'(1);
                  if (dt_q > max_q) max_q <= dt_q;
                  if (gap_q) ev_q[EV_GAPS] <= ev_q[EV_GAPS] + EV_W'(1);
                end
                if (gt_q) prev_q <= ts_q;
              end
            end
            OP_ABORT: begin
              if (s_in && (status_q[sidx] == ST_WRITING))
                status_q[sidx] <= seqneg_q[sidx] ? ST_FREE : ST_READY;
            end
            OP_UNLOCK: begin
              for (int i = 0; i < SLOT_COUNT; i++) begin
                if ((CNT_W'(i) < act) && (status_q[i] == ST_LOCKED)) begin
                  status_q[i] <= ST_FREE;
                  seqv_q[i]   <= 1'b0;
                  seqneg_q[i] <= 1'b1;
                end
              end
              locked_q <= '0;
            end
            OP_RSTAT: begin
              for (int i = 0; i < NUM_EV; i++) ev_q[i] <= '0;
              max_q  <= '0;
              last_q <= '0;
              sum_q  <= '0;
              prev_q <= '0;
            end
            default: ;
          endcase
        end
        S_LSET: begin
          n_q        <= n_sel;
          locked_q   <= lsum[6] ? 6'd63 : lsum[5:0];
          o_locked_q <= lsum[6] ? 6'd63 : lsum[5:0];
          o_ready_q  <= 6'(cnt_q - CNT_W'(n_sel));
          lscan_q    <= 1'b1;
          max_mode_q <= 1'b1;
          if (n_sel == '0) mv_q <= 1'b1;
        end
        S_LOCK: begin
          status_q[best_idx] <= ST_LOCKED;
        end
        S_LRD: begin
          o_ok_q   <= 1'b1;
          o_slot_q <= 5'(best_idx);
          o_ts_q   <= rts;
          o_fr_q   <= SF_W'(rfr);
          o_last_q <= ((lk_q + 6'd1) == n_q);
          mv_q     <= 1'b1;
        end
        S_EMIT: begin
          if (m_tready) begin
            if (o_last_q) begin
              mv_q <= 1'b0;
            end else if (op_q == OP_LOCK) begin
              mv_q <= 1'b0;
              lk_q <= lk_q + 6'd1;
            end else begin
              o_idx_q  <= o_idx_q + 4'd1;
              o_last_q <= ((o_idx_q + 4'd1) == STAT_LDROPS);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat_val = '0;
    if (op_q == OP_RDSTAT) begin
      case (o_idx_q)
        STAT_PUSHED:   stat_val = TS_W'(ev_q[EV_PUSHED]);
        STAT_NOSLOT:   stat_val = TS_W'(ev_q[EV_NOSLOT]);
        STAT_RECYCLED: stat_val = TS_W'(ev_q[EV_RECYCLED]);
        STAT_GAPS:     stat_val = TS_W'(ev_q[EV_GAPS]);
        STAT_MAX:      stat_val = max_q;
        STAT_LAST:     stat_val = last_q;
        STAT_SUM:      stat_val = sum_q;
        STAT_CNT:      stat_val = TS_W'(ev_q[EV_COUNT]);
        STAT_LDROPS:   stat_val = TS_W'(ev_q[EV_LDROPS]);
        default:       stat_val = '0;
      endcase
    end
  end

  assign m_tvalid = mv_q;
  assign m_tlast  = o_last_q;
  assign m_tdata  = {3'b0, o_locked_q, o_ready_q, stat_val, o_idx_q,
                     o_fr_q, o_ts_q, o_slot_q, o_ok_q};

endmodule

[rtl/fsp_checker.sv]
// ----------------------------------------------------------------------------
// fsp_checker
// Port-level checks of the frame slot pool manager, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fsp_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic [fsp_pkg::OUT_W-1:0] m_tdata,
  input logic                     m_tvalid,
  input logic                     m_tready
);
  import fsp_pkg::*;

  `FSP_NEVER(a_idle_no_out, clk_i, rst_ni, s_tready && m_tvalid)
  `FSP_ASSERT(a_busy_after_take, clk_i, rst_ni, s_tvalid && s_tready |=> !s_tready)
  `FSP_ASSERT(a_out_hold, clk_i, rst_ni, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `FSP_ASSERT(a_ok_no_stat, clk_i, rst_ni, m_tvalid && m_tdata[0] |-> m_tdata[184:118] == '0)

endmodule

bind frame_slot_pool_manager fsp_checker u_fsp_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
